### src/lcf_pkg.sv
// lcf_pkg: shared types, widths and register codes of the linear convolution fir
// no dependencies; compiled first

package lcf_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int PROD_W        = 2 * SAMPLE_W;
    localparam int CONV_W        = 35;
    localparam int TAPS_WORD_W   = 64;
    localparam int TAP_COUNT_W   = 4;
    localparam int CFG_INDEX_W   = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_TAPS_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAPS_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAP_COUNT = 2'd2;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [CONV_W-1:0]   t_conv;

    // one pipeline stage's item marker
    typedef struct packed {
        logic vld;
        logic last;
    } t_stage_ctl;

endpackage

### src/lcf_dline.sv
// lcf_dline: sample delay line, input handshake and tail flush sequencing
// depends on lcf_pkg

module lcf_dline #(
    parameter int MAX_TAPS = 8,
    parameter int MW       = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [MW-1:0]      i_m,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lcf_pkg::t_sample   i_sample,
    input  logic               i_final_sample,
    input  logic               i_adv1,
    output lcf_pkg::t_stage_ctl o_ctl,
    output lcf_pkg::t_sample   o_dl [MAX_TAPS]
);
    import lcf_pkg::*;

    localparam int FW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

    t_sample    r_dl [MAX_TAPS];
    t_sample    n_dl [MAX_TAPS];
    logic       r_clr, n_clr;
    logic [FW-1:0] r_left, n_left;
    t_stage_ctl r_ctl, n_ctl;

    logic w_flushing;
    logic w_adv0;
    logic w_produce;

    assign w_flushing = (r_left != '0);
    assign w_adv0     = !r_ctl.vld || i_adv1;
    assign o_in_stall = w_flushing || !w_adv0;
    // a flush step or an accepted beat loads a new window
    assign w_produce  = w_adv0 && (w_flushing || i_in_valid);

    always_comb begin
        n_dl   = r_dl;
        n_clr  = r_clr;
        n_left = r_left;
        n_ctl  = r_ctl;
        if (w_adv0) begin
            n_ctl = '0;
        end
        if (w_produce) begin
            n_dl[0] = w_flushing ? t_sample'(0) : i_sample;
            for (int i = 1; i < MAX_TAPS; i++) begin
                n_dl[i] = r_clr ? t_sample'(0) : r_dl[i-1];
            end
            n_clr     = 1'b0;
            n_ctl.vld = 1'b1;
            if (w_flushing) begin
                n_left     = r_left - FW'(1);
                n_ctl.last = (r_left == FW'(1));
                n_clr      = (r_left == FW'(1));
            end else if (i_final_sample) begin
                if (i_m == MW'(1)) begin
                    n_ctl.last = 1'b1;
                    n_clr      = 1'b1;
                end else begin
                    n_left = FW'(i_m - MW'(1));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= 1'b1;
            r_left <= '0;
            r_ctl  <= '0;
        end else begin
            r_clr  <= n_clr;
            r_left <= n_left;
            r_ctl  <= n_ctl;
        end
    end

    // older entries are zeroed by the clear flag on the next shift
    always_ff @(posedge i_clk) begin
        r_dl <= n_dl;
    end

    assign o_ctl = r_ctl;
    assign o_dl  = r_dl;

endmodule

### src/lcf_mac.sv
// lcf_mac: registered tap products and adder tree into the output register
// depends on lcf_pkg

module lcf_mac #(
    parameter int MAX_TAPS = 8,
    parameter int MW       = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [MW-1:0]       i_m,
    input  lcf_pkg::t_sample    i_taps [MAX_TAPS],
    input  lcf_pkg::t_sample    i_dl [MAX_TAPS],
    input  lcf_pkg::t_stage_ctl i_ctl,
    output logic                o_adv1,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lcf_pkg::t_conv      o_conv_value,
    output logic                o_end_of_run
);
    import lcf_pkg::*;

    t_prod      w_prod [MAX_TAPS];
    t_prod      r_prod [MAX_TAPS];
    t_stage_ctl r_s1;
    t_conv      w_sum;
    t_conv      r_out_value;
    logic       r_out_vld;
    logic       r_out_last;
    logic       w_adv2;

    assign w_adv2 = !r_out_vld || !i_out_stall;
    assign o_adv1 = !r_s1.vld || w_adv2;

    // taps beyond the count in use contribute nothing
    always_comb begin
        for (int i = 0; i < MAX_TAPS; i++) begin
            w_prod[i] = (MW'(i) < i_m) ? t_prod'(i_dl[i] * i_taps[i]) : t_prod'(0);
        end
    end

    always_comb begin
        w_sum = '0;
        for (int i = 0; i < MAX_TAPS; i++) begin
            w_sum = w_sum + {{(CONV_W-PROD_W){r_prod[i][PROD_W-1]}}, r_prod[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1       <= '0;
            r_out_vld  <= 1'b0;
            r_out_last <= 1'b0;
        end else begin
            if (o_adv1) begin
                r_s1 <= i_ctl;
            end
            if (w_adv2) begin
                r_out_vld  <= r_s1.vld;
                r_out_last <= r_s1.last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv1) begin
            r_prod <= w_prod;
        end
        if (w_adv2) begin
            r_out_value <= w_sum;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_conv_value = r_out_value;
    assign o_end_of_run = r_out_last;

endmodule

### src/linear_convolution_fir.sv
// linear_convolution_fir: direct-form fir giving the full linear convolution of a sample stream
// depends on lcf_pkg, lcf_dline, lcf_mac
//
//   channel | signals                                              | handshake
//   --------+------------------------------------------------------+--------------------
//   input   | i_sample, i_final_sample                             | i_in_valid / o_in_stall
//   output  | o_conv_value, o_end_of_run                           | o_out_valid / i_out_stall
//   config  | i_cfg_index, i_cfg_data                              | i_cfg_valid / o_cfg_ready
//
// one beat per cycle while nothing stalls; a result is registered in the delay line, the
// product register and the sum register in that order after the edge that takes its sample
// a final sample holds the input stalled while zeros flush the tail for the remaining taps
// (count after its limits), and the flush waits while the output stalls
// stalls ripple back only as far as the first empty stage
// reset clears the taps, sets tap_count to 1 and empties the delay line

module linear_convolution_fir #(
    parameter int MAX_TAPS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  lcf_pkg::t_sample                     i_sample,
    input  logic                                 i_final_sample,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output lcf_pkg::t_conv                       o_conv_value,
    output logic                                 o_end_of_run,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [lcf_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [lcf_pkg::TAPS_WORD_W-1:0]      i_cfg_data
);
    import lcf_pkg::*;

    localparam int MW = $clog2(MAX_TAPS + 1);

    logic [TAPS_WORD_W-1:0] r_taps_low;
    logic [TAPS_WORD_W-1:0] r_taps_high;
    logic [TAP_COUNT_W-1:0] r_tap_count;
    logic [2*TAPS_WORD_W-1:0] w_taps_all;
    t_sample    w_taps [MAX_TAPS];
    t_sample    w_dl [MAX_TAPS];
    logic [MW-1:0] w_m;
    t_stage_ctl w_s0;
    logic       w_adv1;
    logic       w_in_acc;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taps_low  <= '0;
            r_taps_high <= '0;
            r_tap_count <= TAP_COUNT_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TAPS_LOW:  r_taps_low  <= i_cfg_data;
                CFG_TAPS_HIGH: r_taps_high <= i_cfg_data;
                CFG_TAP_COUNT: r_tap_count <= i_cfg_data[TAP_COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_taps_all = {r_taps_high, r_taps_low};

    always_comb begin
        for (int i = 0; i < MAX_TAPS; i++) begin
            w_taps[i] = w_taps_all[SAMPLE_W*i +: SAMPLE_W];
        end
    end

    // count of zero means one tap, above the build limit saturates
    always_comb begin
        if (r_tap_count == '0) begin
            w_m = MW'(1);
        end else if (r_tap_count > TAP_COUNT_W'(MAX_TAPS)) begin
            w_m = MW'(MAX_TAPS);
        end else begin
            w_m = MW'(r_tap_count);
        end
    end

    lcf_dline #(
        .MAX_TAPS (MAX_TAPS),
        .MW       (MW)
    ) u_dline (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_m            (w_m),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample       (i_sample),
        .i_final_sample (i_final_sample),
        .i_adv1         (w_adv1),
        .o_ctl          (w_s0),
        .o_dl           (w_dl)
    );

    lcf_mac #(
        .MAX_TAPS (MAX_TAPS),
        .MW       (MW)
    ) u_mac (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_m          (w_m),
        .i_taps       (w_taps),
        .i_dl         (w_dl),
        .i_ctl        (w_s0),
        .o_adv1       (w_adv1),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_conv_value (o_conv_value),
        .o_end_of_run (o_end_of_run)
    );

    assign w_in_acc = i_in_valid && !o_in_stall;

    // a final sample with more than one tap must hold off the next beat
    a_flush_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_final_sample && (w_m != MW'(1))) |=> o_in_stall)
        else $error("input not stalled during tail flush");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> w_s0.vld)
        else $error("accepted beat did not reach the delay line stage");

    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_end_of_run |-> o_out_valid)
        else $error("end of run flagged without a valid result");

endmodule
